// File: src/orl_pkg.sv
// Package: shared types, constants and codes for the ordered record list.
package orl_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int POS_W        = 9;
  localparam int COUNT_W      = 9;
  localparam int REC_W        = 64 + 8 + 64 + 16 + 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_UPDATE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_INS  = 2'd1,
    PTR_DEL  = 2'd2,
    PTR_ZERO = 2'd3
  } ptr_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_WALK,
    ST_INS_LAST,
    ST_INS_PUT,
    ST_DEL_WALK,
    ST_DEL_LAST,
    ST_SEARCH,
    ST_UPDATE,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [POS_W-1:0]   position;
    logic [63:0]        id_low;
    logic [7:0]         id_high;
    logic [63:0]        name_low;
    logic [15:0]        name_high;
    logic signed [31:0] score;
  } in_rec_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] record_count;
    logic [63:0]        found_id_low;
    logic [7:0]         found_id_high;
    logic [63:0]        found_name_low;
    logic [15:0]        found_name_high;
    logic signed [31:0] found_score;
  } out_rec_t;

  // One stored record as it sits in the RAM.
  typedef struct packed {
    logic [63:0] key_low;
    logic [7:0]  key_high;
    logic [63:0] label_low;
    logic [15:0] label_high;
    logic [31:0] mark;
  } rec_t;

  typedef struct packed {
    logic     load;
    ptr_sel_t ptr_sel;
    logic     rd;
    logic     dir_up;
    logic     shift;
    logic     put;
    logic     upd;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     set_st;
    status_t  st;
    logic     found;
    logic     reply;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       ins_ok;
    logic       del_ok;
    logic       full;
    logic       empty;
    logic       tail_ins;
    logic       tail_del;
    logic       end_up;
    logic       end_dn;
    logic       more;
    logic       hit;
    logic       lag_vld;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: src/ordered_record_list.sv
// Top level: ordered record list with positional insert/delete and id lookup.
//
//   channel  ports                          transaction moves
//   in       in_valid, in_stall, in_data    one request (insert/delete/read/update)
//   out      out_valid, out_stall, out_data one result (status, count, found record)
//
// One request at a time; the controller returns to idle after each reply, before the next
// request is taken. Inserts and deletes walk the record RAM one entry a cycle, reading one
// record and writing its neighbour each cycle; reads and updates search it from the start.
// A waiting result does not stop the next request from being taken; only its reply waits.
// Reset empties the list; record storage is not cleared.
module ordered_record_list #(
  parameter int CAPACITY = orl_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  orl_pkg::in_rec_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output orl_pkg::out_rec_t out_data
);

  orl_pkg::dp_cmd_t  cmd;
  orl_pkg::dp_stat_t stat;

  orl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  orl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Busy straight after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while controller not idle");

  // A new result only appears while a request is in progress
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a request in progress");

  // Failed requests carry no record
  a_failed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != orl_pkg::STAT_DONE) |->
      (out_data.found_id_low == '0) && (out_data.found_score == '0))
    else $error("failed request carries record data");

  // A full list reports the full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == orl_pkg::STAT_FULL) |->
      (out_data.record_count == 9'(CAPACITY)))
    else $error("list full reported with wrong record count");

endmodule

// File: src/orl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module orl_ram #(
  parameter int  WIDTH = orl_pkg::REC_W,
  parameter int  DEPTH = orl_pkg::CAPACITY_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // Hold the last read word while no read is issued.
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/orl_datapath.sv
// Datapath: request registers, record RAM, walk pointers and result register.
module orl_datapath #(
  parameter int CAPACITY = orl_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  orl_pkg::dp_cmd_t  cmd,
  output orl_pkg::dp_stat_t stat,
  input  orl_pkg::in_rec_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output orl_pkg::out_rec_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > orl_pkg::POS_W) ? CNT_W : orl_pkg::POS_W;

  // Request registers
  logic [1:0]        action_r;
  logic [CMP_W-1:0]  pos_r;
  logic [63:0]       key_low_r;
  logic [7:0]        key_high_r;
  logic [63:0]       name_low_r;
  logic [15:0]       name_high_r;
  logic [31:0]       score_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  lag_r;
  logic              lag_vld_r;
  orl_pkg::status_t  status_r;
  logic              found_r;
  logic              out_valid_r;
  orl_pkg::out_rec_t out_data_r, out_data_nxt;

  logic [63:0]       trim_low;
  logic [7:0]        trim_high;
  logic [CMP_W-1:0]  pos_m1;
  logic [CMP_W-1:0]  cnt_x;

  logic              wr_en, move;
  logic [IDX_W-1:0]  wr_addr;
  orl_pkg::rec_t     wr_rec, rd_rec, new_rec;
  logic [orl_pkg::REC_W-1:0] rd_word;

  // Clear every id byte from the first zero byte on.
  always_comb begin
    logic seen;
    seen      = 1'b0;
    trim_low  = in_data.id_low;
    for (int b = 0; b < 8; b++) begin
      if (in_data.id_low[8*b +: 8] == 8'd0) begin
        seen = 1'b1;
      end
      if (seen) begin
        trim_low[8*b +: 8] = 8'd0;
      end
    end
    trim_high = seen ? 8'd0 : in_data.id_high;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r    <= in_data.action;
      pos_r       <= CMP_W'(in_data.position);
      key_low_r   <= trim_low;
      key_high_r  <= trim_high;
      name_low_r  <= in_data.name_low;
      name_high_r <= in_data.name_high;
      score_r     <= in_data.score;
    end
  end

  assign pos_m1 = pos_r - 1'b1;
  assign cnt_x  = CMP_W'(count_r);

  // Walk pointer: start point by command, then step once per read
  always_comb begin
    ptr_nxt = ptr_r;
    case (cmd.ptr_sel)
      orl_pkg::PTR_INS:  ptr_nxt = count_r - 1'b1;
      orl_pkg::PTR_DEL:  ptr_nxt = pos_r[CNT_W-1:0];
      orl_pkg::PTR_ZERO: ptr_nxt = '0;
      orl_pkg::PTR_HOLD: begin
        if (cmd.rd) begin
          ptr_nxt = cmd.dir_up ? ptr_r + 1'b1 : ptr_r - 1'b1;
        end
      end
      default: ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      lag_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      lag_vld_r <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.rd) begin
      lag_r <= ptr_r[IDX_W-1:0];
    end
    if (cmd.set_st) begin
      status_r <= cmd.st;
      found_r  <= cmd.found;
    end
  end

  // RAM write side: shifted record, new record, or rewritten score
  assign move    = lag_vld_r && cmd.shift;
  assign rd_rec  = orl_pkg::rec_t'(rd_word);

  always_comb begin
    new_rec.key_low    = key_low_r;
    new_rec.key_high   = key_high_r;
    new_rec.label_low  = name_low_r;
    new_rec.label_high = name_high_r;
    new_rec.mark       = score_r;
  end

  always_comb begin
    wr_en   = move || cmd.put || cmd.upd;
    wr_addr = lag_r;
    wr_rec  = rd_rec;
    if (move) begin
      wr_addr = cmd.dir_up ? lag_r - 1'b1 : lag_r + 1'b1;
    end else if (cmd.put) begin
      wr_addr = pos_m1[IDX_W-1:0];
      wr_rec  = new_rec;
    end else if (cmd.upd) begin
      wr_rec.mark = score_r;
    end
  end

  orl_ram #(
    .WIDTH (orl_pkg::REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_en   (cmd.rd),
    .rd_addr (ptr_r[IDX_W-1:0]),
    .rd_data (rd_word)
  );

  // Result register
  always_comb begin
    out_data_nxt.status          = status_r;
    out_data_nxt.record_count    = cnt_x[orl_pkg::COUNT_W-1:0];
    out_data_nxt.found_id_low    = found_r ? rd_rec.key_low : '0;
    out_data_nxt.found_id_high   = found_r ? rd_rec.key_high : '0;
    out_data_nxt.found_name_low  = found_r ? rd_rec.label_low : '0;
    out_data_nxt.found_name_high = found_r ? rd_rec.label_high : '0;
    out_data_nxt.found_score     = found_r ? rd_rec.mark : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.reply) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.action   = action_r;
    stat.ins_ok   = (pos_r != '0) && (pos_m1 <= cnt_x);
    stat.del_ok   = (pos_r != '0) && (pos_r <= cnt_x);
    stat.full     = (count_r == CNT_W'(CAPACITY));
    stat.empty    = (count_r == '0);
    stat.tail_ins = (pos_m1 == cnt_x);
    stat.tail_del = (pos_r == cnt_x);
    stat.end_up   = (CMP_W'(ptr_r) == pos_m1);
    stat.end_dn   = (ptr_r == count_r - 1'b1);
    stat.more     = (ptr_r < count_r);
    stat.hit      = lag_vld_r && (rd_rec.key_low == key_low_r)
                    && (rd_rec.key_high == key_high_r);
    stat.lag_vld  = lag_vld_r;
    stat.out_free = !out_valid_r || !out_stall;
  end

endmodule

// File: src/orl_ctrl.sv
// Controller: sequences each request over the datapath.
module orl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  orl_pkg::dp_stat_t stat,
  output orl_pkg::dp_cmd_t  cmd
);

  orl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= orl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      orl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = orl_pkg::ST_DECODE;
        end
      end
      orl_pkg::ST_DECODE: begin
        cmd.set_st = 1'b1;
        cmd.st     = orl_pkg::STAT_DONE;
        if (stat.action == orl_pkg::ACT_INSERT) begin
          if (!stat.ins_ok) begin
            cmd.st    = orl_pkg::STAT_BAD_POS;
            state_nxt = orl_pkg::ST_REPLY;
          end else if (stat.full) begin
            cmd.st    = orl_pkg::STAT_FULL;
            state_nxt = orl_pkg::ST_REPLY;
          end else if (stat.tail_ins) begin
            state_nxt = orl_pkg::ST_INS_PUT;
          end else begin
            cmd.ptr_sel = orl_pkg::PTR_INS;
            state_nxt   = orl_pkg::ST_INS_WALK;
          end
        end else if (stat.action == orl_pkg::ACT_DELETE) begin
          if (!stat.del_ok) begin
            cmd.st    = orl_pkg::STAT_BAD_POS;
            state_nxt = orl_pkg::ST_REPLY;
          end else if (stat.tail_del) begin
            state_nxt = orl_pkg::ST_DEL_LAST;
          end else begin
            cmd.ptr_sel = orl_pkg::PTR_DEL;
            state_nxt   = orl_pkg::ST_DEL_WALK;
          end
        end else begin
          if (stat.empty) begin
            cmd.st    = orl_pkg::STAT_NOT_FOUND;
            state_nxt = orl_pkg::ST_REPLY;
          end else begin
            cmd.ptr_sel = orl_pkg::PTR_ZERO;
            state_nxt   = orl_pkg::ST_SEARCH;
          end
        end
      end
      // Read downwards, write each record one place up
      orl_pkg::ST_INS_WALK: begin
        cmd.rd    = 1'b1;
        cmd.shift = 1'b1;
        if (stat.end_up) begin
          state_nxt = orl_pkg::ST_INS_LAST;
        end
      end
      orl_pkg::ST_INS_LAST: begin
        cmd.shift = 1'b1;
        state_nxt = orl_pkg::ST_INS_PUT;
      end
      orl_pkg::ST_INS_PUT: begin
        cmd.put     = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = orl_pkg::ST_REPLY;
      end
      // Read upwards, write each record one place down
      orl_pkg::ST_DEL_WALK: begin
        cmd.rd     = 1'b1;
        cmd.dir_up = 1'b1;
        cmd.shift  = 1'b1;
        if (stat.end_dn) begin
          state_nxt = orl_pkg::ST_DEL_LAST;
        end
      end
      orl_pkg::ST_DEL_LAST: begin
        cmd.dir_up  = 1'b1;
        cmd.shift   = 1'b1;
        cmd.cnt_dec = 1'b1;
        state_nxt   = orl_pkg::ST_REPLY;
      end
      orl_pkg::ST_SEARCH: begin
        cmd.dir_up = 1'b1;
        if (stat.hit) begin
          // Stop reading so the matching record stays on the RAM output
          cmd.set_st = 1'b1;
          cmd.st     = orl_pkg::STAT_DONE;
          if (stat.action == orl_pkg::ACT_READ) begin
            cmd.found = 1'b1;
            state_nxt = orl_pkg::ST_REPLY;
          end else begin
            state_nxt = orl_pkg::ST_UPDATE;
          end
        end else if (!stat.lag_vld && !stat.more) begin
          cmd.set_st = 1'b1;
          cmd.st     = orl_pkg::STAT_NOT_FOUND;
          state_nxt  = orl_pkg::ST_REPLY;
        end else begin
          cmd.rd = stat.more;
        end
      end
      orl_pkg::ST_UPDATE: begin
        cmd.upd   = 1'b1;
        state_nxt = orl_pkg::ST_REPLY;
      end
      orl_pkg::ST_REPLY: begin
        if (stat.out_free) begin
          cmd.reply = 1'b1;
          state_nxt = orl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = orl_pkg::ST_IDLE;
    endcase
  end

endmodule
